### hw/rtl/imfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imfc_pkg
// Types, constants and the byte-wide CRC step shared by the IMU frame checker.
// ----------------------------------------------------------------------------
package imfc_pkg;

  localparam int unsigned IdxBits   = 5;
  localparam int unsigned WordCount = 9;
  localparam int unsigned HeldBits  = 16 * WordCount;

  localparam logic [IdxBits-1:0] CrcBytes  = 5'd27;
  localparam logic [IdxBits-1:0] FrameLast = 5'd28;
  localparam logic [IdxBits-1:0] IdleIndex = 5'd29;
  localparam logic [IdxBits-1:0] AccFirst  = 5'd3;
  localparam logic [IdxBits-1:0] RateLast  = 5'd14;
  localparam logic [IdxBits-1:0] TiltFirst = 5'd21;
  localparam logic [IdxBits-1:0] TiltLast  = 5'd26;
  localparam logic [3:0]         TiltSlot  = 4'd6;

  localparam logic [15:0] CrcPreset = 16'hFFFF;
  localparam logic [15:0] CrcPoly   = 16'hA001;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic               crc_ok;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    logic signed [15:0] tilt_x;
    logic signed [15:0] tilt_y;
    logic signed [15:0] tilt_z;
  } out_item_t;

  // Reflected CRC-16, one byte, LSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### hw/rtl/imu_frame_crc_checker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_frame_crc_checker_top
// Modbus RTU 29-byte sensor reply checker with CRC-16 and held IMU words.
// ----------------------------------------------------------------------------
// Takes one byte per clock cycle with no gaps needed: the byte-wide CRC-16 step,
// the word capture and the frame position counter all update in the cycle the
// byte is transferred. Byte 28 of each frame loads the result register, which
// presents the result on the next cycle; input stalls only while that register
// holds a result the consumer has not yet taken. A start flag restarts the
// frame; bytes beyond byte 28 are dropped until the next start flag.
module imu_frame_crc_checker_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  imfc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output imfc_pkg::out_item_t out_data
);

  logic [imfc_pkg::IdxBits-1:0] idx_r, idx_nxt;
  logic [15:0]                  crc_r, crc_nxt;
  logic [7:0]                   low_r, low_nxt;
  logic [15:0]                  cap_r [imfc_pkg::WordCount];
  logic [15:0]                  held_r [imfc_pkg::WordCount];
  logic [15:0]                  held_nxt [imfc_pkg::WordCount];
  logic                         out_valid_r, out_valid_nxt;
  imfc_pkg::out_item_t          out_data_r, out_data_nxt;

  logic                         accept;
  logic [imfc_pkg::IdxBits-1:0] pos;
  logic [15:0]                  crc_base;
  logic [3:0]                   slot;
  logic                         slot_hit;
  logic                         crc_ok;
  logic                         last_byte;

  assign in_ready  = out_ready || !out_valid_r;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign pos       = in_data.frame_start ? '0 : idx_r;
  assign crc_base  = in_data.frame_start ? imfc_pkg::CrcPreset : crc_r;
  assign last_byte = (pos == imfc_pkg::FrameLast);
  assign crc_ok    = (low_r == crc_base[7:0]) && (in_data.rx_byte == crc_base[15:8]);

  always_comb begin
    slot     = '0;
    slot_hit = 1'b0;
    if (pos >= imfc_pkg::AccFirst && pos <= imfc_pkg::RateLast) begin
      slot_hit = 1'b1;
      slot     = 4'((pos - imfc_pkg::AccFirst) >> 1);
    end else if (pos >= imfc_pkg::TiltFirst && pos <= imfc_pkg::TiltLast) begin
      slot_hit = 1'b1;
      slot     = 4'((pos - imfc_pkg::TiltFirst) >> 1) + imfc_pkg::TiltSlot;
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    crc_nxt = crc_r;
    low_nxt = low_r;
    for (int j = 0; j < imfc_pkg::WordCount; j++) begin
      held_nxt[j] = held_r[j];
    end
    if (accept) begin
      crc_nxt = crc_base;
      if (pos > imfc_pkg::FrameLast) begin
        idx_nxt = imfc_pkg::IdleIndex;
      end else begin
        idx_nxt = pos + imfc_pkg::IdxBits'(1);
        if (pos < imfc_pkg::CrcBytes) begin
          crc_nxt = imfc_pkg::crc_byte(crc_base, in_data.rx_byte);
        end else if (pos == imfc_pkg::CrcBytes) begin
          low_nxt = in_data.rx_byte;
        end else if (crc_ok) begin
          for (int j = 0; j < imfc_pkg::WordCount; j++) begin
            held_nxt[j] = cap_r[j];
          end
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if (accept && last_byte) begin
      out_valid_nxt        = 1'b1;
      out_data_nxt.crc_ok  = crc_ok;
      out_data_nxt.accel_x = held_nxt[0];
      out_data_nxt.accel_y = held_nxt[1];
      out_data_nxt.accel_z = held_nxt[2];
      out_data_nxt.rate_x  = held_nxt[3];
      out_data_nxt.rate_y  = held_nxt[4];
      out_data_nxt.rate_z  = held_nxt[5];
      out_data_nxt.tilt_x  = held_nxt[6];
      out_data_nxt.tilt_y  = held_nxt[7];
      out_data_nxt.tilt_z  = held_nxt[8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      crc_r       <= imfc_pkg::CrcPreset;
      low_r       <= '0;
      out_valid_r <= 1'b0;
      for (int j = 0; j < imfc_pkg::WordCount; j++) begin
        held_r[j] <= '0;
      end
    end else begin
      idx_r       <= idx_nxt;
      crc_r       <= crc_nxt;
      low_r       <= low_nxt;
      out_valid_r <= out_valid_nxt;
      for (int j = 0; j < imfc_pkg::WordCount; j++) begin
        held_r[j] <= held_nxt[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (accept && slot_hit) begin
      if (pos[0]) begin
        cap_r[slot][15:8] <= in_data.rx_byte;
      end else begin
        cap_r[slot][7:0] <= in_data.rx_byte;
      end
    end
  end

endmodule

### hw/rtl/imfc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imfc_checker
// Port-level assertions for the IMU frame checker, bound to the top level.
// ----------------------------------------------------------------------------
module imfc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input imfc_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input imfc_pkg::out_item_t out_data
);

  logic [imfc_pkg::HeldBits-1:0] last_held_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_held_r <= '0;
    end else if (out_valid && out_ready) begin
      last_held_r <= out_data[imfc_pkg::HeldBits-1:0];
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_out_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result without an input transfer");

  a_ready_only_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with free result register");

  a_bad_crc_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.crc_ok |-> out_data[imfc_pkg::HeldBits-1:0] == last_held_r)
    else $error("held words changed on CRC mismatch");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind imu_frame_crc_checker_top imfc_checker u_imfc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

### tb/sv/tb_imu_frame_crc_checker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_imu_frame_crc_checker_top
// Self-checking bench for the 29-byte sensor reply checker. Frames are built
// with a locally computed CRC-16, sent byte by byte over the input channel and
// predicted by an in-bench model of the frame position, CRC, word capture and
// held words. A directed frame table comes first, then random frames, noise
// and broken frames, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_imu_frame_crc_checker_top;

  localparam int ItemTarget   = 1950;
  localparam int CalmItems    = 300;
  localparam int HoldOffCount = 150;
  localparam int HoldOffAfter = 20;
  localparam int StallLimit   = 4000;
  localparam int DrainCycles  = 30;
  localparam int FrameLen     = 29;
  localparam int ReportMax    = 10;

  typedef enum logic [1:0] {CrcGood, CrcBadLo, CrcBadHi} crc_mode_t;

  typedef struct {
    bit          start;
    bit          rnd;
    logic [15:0] word;
    crc_mode_t   crc;
    int          cut;
    int          tail;
    bit          typed;
    bit          want_ok;
    logic [15:0] want_word;
  } frame_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  imfc_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_ready;
  imfc_pkg::out_item_t out_data;

  // predictor state
  logic [4:0]  p_idx;
  logic [15:0] p_crc;
  logic [7:0]  p_lo;
  logic [15:0] p_capt [imfc_pkg::WordCount];
  logic [15:0] p_held [imfc_pkg::WordCount];

  imfc_pkg::out_item_t reply_q [$];
  logic [7:0]          frame_buf [FrameLen];
  frame_row_t          dir_rows [14];
  string               word_name [imfc_pkg::WordCount] = '{"accel_x", "accel_y", "accel_z",
                                                           "rate_x", "rate_y", "rate_z",
                                                           "tilt_x", "tilt_y", "tilt_z"};

  bit                  use_typed;
  imfc_pkg::out_item_t typed_reply;
  bit                  calm;
  int                  gap_odds;
  int                  items_used;
  int                  replies_due;
  int                  replies_taken;
  int                  fail_count;
  int                  quiet_cycles;

  imu_frame_crc_checker_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = c;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ b[i];
      r = r >> 1;
      if (fb) begin
        r = r ^ 16'hA001;
      end
    end
    return r;
  endfunction

  function automatic imfc_pkg::out_item_t all_words(input bit ok, input logic [15:0] w);
    return {ok, w, w, w, w, w, w, w, w, w};
  endfunction

  function automatic bit frame_step(input logic [7:0] b, input logic st,
                                    output imfc_pkg::out_item_t res);
    logic [4:0] at;
    int         slot;
    bit         ok;
    res = '0;
    if (st) begin
      p_idx = '0;
      p_crc = imfc_pkg::CrcPreset;
    end
    at = p_idx;
    if (at > imfc_pkg::FrameLast) begin
      p_idx = imfc_pkg::IdleIndex;
      return 1'b0;
    end
    p_idx = at + 5'd1;
    if (at < imfc_pkg::CrcBytes) begin
      p_crc = crc_next(p_crc, b);
      slot = -1;
      if (at >= imfc_pkg::AccFirst && at <= imfc_pkg::RateLast) begin
        slot = (at - imfc_pkg::AccFirst) >> 1;
      end else if (at >= imfc_pkg::TiltFirst && at <= imfc_pkg::TiltLast) begin
        slot = ((at - imfc_pkg::TiltFirst) >> 1) + imfc_pkg::TiltSlot;
      end
      if (slot >= 0) begin
        if (at[0]) begin
          p_capt[slot][15:8] = b;
        end else begin
          p_capt[slot][7:0] = b;
        end
      end
      return 1'b0;
    end
    if (at == imfc_pkg::CrcBytes) begin
      p_lo = b;
      return 1'b0;
    end
    ok = (p_lo == p_crc[7:0]) && (b == p_crc[15:8]);
    if (ok) begin
      p_held = p_capt;
    end
    res = {ok, p_held[0], p_held[1], p_held[2], p_held[3], p_held[4], p_held[5], p_held[6],
           p_held[7], p_held[8]};
    return 1'b1;
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 15))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic int pick_odds();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 4;
      default: return 16;
    endcase
  endfunction

  task automatic build_frame(input bit rnd, input logic [15:0] w, input crc_mode_t m);
    logic [15:0] c;
    logic [15:0] v;
    int          at;
    for (int i = 0; i < FrameLen; i++) begin
      frame_buf[i] = 8'($urandom_range(0, 255));
    end
    for (int j = 0; j < imfc_pkg::WordCount; j++) begin
      v = rnd ? pick_word() : w;
      at = (j < 6) ? 3 + 2 * j : 21 + 2 * (j - 6);
      frame_buf[at]     = v[15:8];
      frame_buf[at + 1] = v[7:0];
    end
    c = imfc_pkg::CrcPreset;
    for (int i = 0; i < imfc_pkg::CrcBytes; i++) begin
      c = crc_next(c, frame_buf[i]);
    end
    frame_buf[27] = c[7:0];
    frame_buf[28] = c[15:8];
    if (m == CrcBadLo) begin
      frame_buf[27] = frame_buf[27] ^ 8'($urandom_range(1, 255));
    end else if (m == CrcBadHi) begin
      frame_buf[28] = frame_buf[28] ^ 8'($urandom_range(1, 255));
    end
  endtask

  // entered just after a falling edge, leaves just after one
  task automatic send_byte(input logic [7:0] b, input logic st);
    imfc_pkg::out_item_t res;
    if (!calm && gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{rx_byte: b, frame_start: st};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_used++;
    if (frame_step(b, st, res)) begin
      reply_q.push_back(use_typed ? typed_reply : res);
      replies_due++;
    end
    @(negedge clk);
  endtask

  task automatic send_frame(input bit start, input int cut, input int tail);
    int n;
    n = (cut == 0) ? FrameLen : cut;
    for (int i = 0; i < n; i++) begin
      send_byte(frame_buf[i], start && i == 0);
    end
    for (int i = 0; i < tail; i++) begin
      send_byte(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  // result check
  always @(posedge clk) begin
    logic [144:0] got;
    logic [144:0] want;
    if (rst_n && out_valid && out_ready) begin
      replies_taken++;
      if (reply_q.size() == 0) begin
        fail_count++;
        if (fail_count <= ReportMax) begin
          $display("unexpected result %h", out_data);
        end
      end else begin
        want = reply_q.pop_front();
        got  = out_data;
        if (got[144] !== want[144]) begin
          fail_count++;
          if (fail_count <= ReportMax) begin
            $display("result %0d crc_ok: expected %b, got %b", replies_taken, want[144], got[144]);
          end
        end
        for (int j = 0; j < imfc_pkg::WordCount; j++) begin
          if (got[16 * (8 - j) +: 16] !== want[16 * (8 - j) +: 16]) begin
            fail_count++;
            if (fail_count <= ReportMax) begin
              $display("result %0d %s: expected %h, got %h", replies_taken, word_name[j],
                       want[16 * (8 - j) +: 16], got[16 * (8 - j) +: 16]);
            end
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("FAIL imu_frame_crc_checker_top");
      $finish;
    end
  end

  // result channel: random stalls, one long hold-off
  initial begin
    bit held_off;
    int rx_odds;
    held_off = 1'b0;
    rx_odds  = 0;
    out_ready = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      if ($urandom_range(0, 63) == 0) begin
        rx_odds = pick_odds();
      end
      if (!held_off && replies_taken >= HoldOffAfter) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (HoldOffCount) @(negedge clk);
      end else if (!calm && rx_odds != 0 && $urandom_range(0, rx_odds - 1) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  initial begin
    int kind;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    p_idx         = '0;
    p_crc         = imfc_pkg::CrcPreset;
    p_lo          = '0;
    calm          = 1'b0;
    gap_odds      = 0;
    use_typed     = 1'b0;
    typed_reply   = '0;
    items_used    = 0;
    replies_due   = 0;
    replies_taken = 0;
    fail_count    = 0;
    quiet_cycles  = 0;
    for (int j = 0; j < imfc_pkg::WordCount; j++) begin
      p_capt[j] = '0;
      p_held[j] = '0;
    end
    dir_rows = '{
      '{1'b0, 1'b0, 16'h1234, CrcBadLo, 0,  0, 1'b1, 1'b0, 16'h0000},
      '{1'b1, 1'b0, 16'h7FFF, CrcGood,  0,  0, 1'b1, 1'b1, 16'h7FFF},
      '{1'b1, 1'b0, 16'h8000, CrcBadHi, 0,  0, 1'b1, 1'b0, 16'h7FFF},
      '{1'b1, 1'b0, 16'h8000, CrcGood,  0,  2, 1'b1, 1'b1, 16'h8000},
      '{1'b0, 1'b0, 16'h5A5A, CrcGood,  0,  0, 1'b0, 1'b0, 16'h0000},
      '{1'b1, 1'b0, 16'hFFFF, CrcGood,  0,  0, 1'b1, 1'b1, 16'hFFFF},
      '{1'b1, 1'b0, 16'h0000, CrcGood,  15, 0, 1'b0, 1'b0, 16'h0000},
      '{1'b1, 1'b0, 16'h0000, CrcGood,  0,  0, 1'b1, 1'b1, 16'h0000},
      '{1'b1, 1'b1, 16'h0000, CrcGood,  28, 0, 1'b0, 1'b0, 16'h0000},
      '{1'b1, 1'b0, 16'h00FF, CrcGood,  1,  0, 1'b0, 1'b0, 16'h0000},
      '{1'b1, 1'b0, 16'hFF00, CrcGood,  0,  0, 1'b1, 1'b1, 16'hFF00},
      '{1'b1, 1'b1, 16'h0000, CrcBadHi, 0,  0, 1'b0, 1'b0, 16'h0000},
      '{1'b1, 1'b1, 16'h0000, CrcGood,  0,  0, 1'b0, 1'b0, 16'h0000},
      '{1'b1, 1'b1, 16'h0000, CrcBadLo, 0,  0, 1'b0, 1'b0, 16'h0000}
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[r]) begin
      gap_odds    = pick_odds();
      use_typed   = dir_rows[r].typed;
      typed_reply = all_words(dir_rows[r].want_ok, dir_rows[r].want_word);
      build_frame(dir_rows[r].rnd, dir_rows[r].word, dir_rows[r].crc);
      send_frame(dir_rows[r].start, dir_rows[r].cut, dir_rows[r].tail);
    end
    use_typed = 1'b0;

    while (items_used < ItemTarget) begin
      calm = (items_used >= ItemTarget - CalmItems);
      if ($urandom_range(0, 3) == 0) begin
        gap_odds = pick_odds();
      end
      kind = $urandom_range(0, 99);
      if (kind < 62) begin
        build_frame(1'b1, 16'h0000, CrcGood);
        send_frame(1'b1, 0, 0);
      end else if (kind < 74) begin
        build_frame(1'b1, 16'h0000, $urandom_range(0, 1) ? CrcBadLo : CrcBadHi);
        send_frame(1'b1, 0, 0);
      end else if (kind < 82) begin
        build_frame(1'b1, 16'h0000, CrcGood);
        send_frame(1'b1, $urandom_range(1, 28), 0);
      end else if (kind < 88) begin
        build_frame(1'b1, 16'h0000, CrcGood);
        send_frame(1'b1, 0, $urandom_range(1, 6));
      end else if (kind < 93) begin
        repeat ($urandom_range(1, 8)) begin
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        end
      end else begin
        build_frame(1'b1, 16'h0000, CrcGood);
        send_frame(1'b0, 0, 0);
      end
    end

    in_valid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS imu_frame_crc_checker_top");
    end else begin
      $display("FAIL imu_frame_crc_checker_top");
    end
    $finish;
  end

endmodule
